### src/ioc_pkg.sv
// Package for the IMU offset calibration and scaling block.
// Holds the field widths, constants and shared types; it depends on nothing.

package ioc_pkg;

    localparam int AxisW     = 16;
    localparam int AccW      = 17;
    localparam int GyroW     = 18;
    localparam int Axes      = 6;
    localparam int AccAxes   = 3;
    localparam int CountW    = 8;
    localparam int GyroShift = 10;
    localparam int ProdW     = AccW + 12;
    localparam int InDataW   = Axes * AxisW;
    localparam int OutDataW  = 112;
    localparam int OutUsedW  = AccAxes * AccW + (Axes - AccAxes) * GyroW;

    localparam logic signed [11:0] GyroMul         = 12'sd2001;
    localparam logic [CountW-1:0]   CalibCountReset = 8'd10;
    localparam logic                OpSample        = 1'b0;
    localparam logic                OpStartCalib    = 1'b1;

    typedef logic signed [AxisW-1:0] t_axis;
    typedef logic signed [AccW-1:0]  t_diff;
    typedef logic signed [GyroW-1:0] t_rate;

    typedef struct packed {
        logic calibrating;
        logic calib_done;
    } t_flags;

endpackage

### src/imu_offset_calibrate_scale_top.sv
// Top level of the IMU offset calibration and scaling block.
// Uses ioc_pkg and instantiates six ioc_lane lanes and ioc_merge.
//
// Usage: the input channel carries either a six-axis sample (tuser = 0) or
// a command that starts a calibration run (tuser = 1). Each sample gives one
// output item; a command gives none. During a run, the first sample loads the
// offsets and later samples average into them; the item that ends the run
// has calib_done set, and every sample taken into the offsets has
// calibrating set. Accel outputs are raw minus offset, gyro outputs are
// (raw minus offset) * 2001 >> 10.
// The run length is written through i_cfg_we and i_cfg_wdata; the user must
// write it only while idle, as the block does not enforce this. A sample
// passes the lane register, then the output register behind o_m_tvalid. One
// item is taken every cycle while the receiver keeps up; these two registers
// form a two-deep pipeline, so the input keeps accepting while one result
// waits. When the receiver stalls, both stages fill and o_s_tready falls.
// After reset the offsets are zero, no run is active and the run length is 10.

module imu_offset_calibrate_scale_top (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [ioc_pkg::CountW-1:0]    i_cfg_wdata,
    input  logic                          i_s_tvalid,
    output logic                          o_s_tready,
    // Fields from bit 0: accel_x_raw, accel_y_raw, accel_z_raw,
    // gyro_x_raw, gyro_y_raw, gyro_z_raw.
    input  logic [ioc_pkg::InDataW-1:0]   i_s_tdata,
    // Fields from bit 0: op.
    input  logic                          i_s_tuser,
    output logic                          o_m_tvalid,
    input  logic                          i_m_tready,
    // Fields from bit 0: accel_x_g, accel_y_g, accel_z_g, gyro_x_rate,
    // gyro_y_rate, gyro_z_rate, then zero fill.
    output logic [ioc_pkg::OutDataW-1:0]  o_m_tdata,
    // Fields from bit 0: calib_done, calibrating.
    output ioc_pkg::t_flags               o_m_tuser
);
    import ioc_pkg::*;

    logic [CountW-1:0] r_count;
    logic [CountW-1:0] r_remaining;
    logic              r_first;
    logic              r_v1;
    t_flags            r_flags1;
    t_flags            n_flags1;
    logic              w_accept;
    logic              w_sample;
    logic              w_start;
    logic              w_cal;
    logic              w_take;
    t_diff             w_diff [Axes];

    assign w_accept = i_s_tvalid && o_s_tready;
    assign w_sample = w_accept && (i_s_tuser == OpSample);
    assign w_start  = w_accept && (i_s_tuser == OpStartCalib);
    assign w_cal    = w_sample && (r_remaining != '0);

    assign o_s_tready = !r_v1 || w_take;

    always_comb begin
        n_flags1.calibrating = w_cal;
        n_flags1.calib_done  = w_cal && (r_remaining == CountW'(1));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= CalibCountReset;
            r_remaining <= '0;
            r_first     <= 1'b0;
            r_v1        <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_count <= i_cfg_wdata;
            end
            if (w_start) begin
                r_remaining <= r_count;
                r_first     <= 1'b1;
            end else if (w_cal) begin
                r_remaining <= r_remaining - CountW'(1);
                r_first     <= 1'b0;
            end
            if (w_sample) begin
                r_v1 <= 1'b1;
            end else if (w_take) begin
                r_v1 <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_sample) begin
            r_flags1 <= n_flags1;
        end
    end

    for (genvar g = 0; g < Axes; g++) begin : g_lane
        ioc_lane u_lane (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_load   (w_sample),
            .i_update (w_cal),
            .i_first  (r_first),
            .i_sample (t_axis'(i_s_tdata[g*AxisW +: AxisW])),
            .o_diff   (w_diff[g])
        );
    end

    ioc_merge u_merge (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (r_v1),
        .i_diff   (w_diff),
        .i_flags  (r_flags1),
        .i_tready (i_m_tready),
        .o_take   (w_take),
        .o_tvalid (o_m_tvalid),
        .o_tdata  (o_m_tdata),
        .o_tuser  (o_m_tuser)
    );

endmodule

### src/ioc_lane.sv
// One axis lane: keeps the axis offset, averages samples into it during a
// calibration run and registers the sample minus the offset. Uses ioc_pkg.

module ioc_lane (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_load,
    input  logic          i_update,
    input  logic          i_first,
    input  ioc_pkg::t_axis i_sample,
    output ioc_pkg::t_diff o_diff
);
    import ioc_pkg::*;

    t_axis r_offset;
    t_axis n_offset;
    t_diff r_diff;
    t_diff w_sum;
    t_diff w_sum_adj;
    t_axis w_offset_used;

    assign w_sum     = t_diff'(r_offset) + t_diff'(i_sample);
    assign w_sum_adj = w_sum + (w_sum[AccW-1] ? t_diff'(1) : t_diff'(0));

    always_comb begin
        n_offset = r_offset;
        if (i_update) begin
            if (i_first) begin
                n_offset = i_sample;
            end else begin
                n_offset = t_axis'(w_sum_adj >>> 1);
            end
        end
    end

    assign w_offset_used = n_offset;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_offset <= '0;
        end else begin
            r_offset <= n_offset;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_diff <= t_diff'(i_sample) - t_diff'(w_offset_used);
        end
    end

    assign o_diff = r_diff;

endmodule

### src/ioc_merge.sv
// Merging and output stage: scales the gyroscope lanes, packs all lanes and
// the calibration flags into the output register. Uses ioc_pkg.

module ioc_merge (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    input  ioc_pkg::t_diff                 i_diff [ioc_pkg::Axes],
    input  ioc_pkg::t_flags                i_flags,
    input  logic                           i_tready,
    output logic                           o_take,
    output logic                           o_tvalid,
    output logic [ioc_pkg::OutDataW-1:0]   o_tdata,
    output ioc_pkg::t_flags                o_tuser
);
    import ioc_pkg::*;

    logic                r_valid;
    logic [OutDataW-1:0] r_data;
    logic [OutDataW-1:0] n_data;
    t_flags              r_flags;
    logic signed [ProdW-1:0] w_prod [Axes-AccAxes];

    assign o_take = i_valid && (!r_valid || i_tready);

    for (genvar g = 0; g < Axes - AccAxes; g++) begin : g_gyro
        assign w_prod[g] = i_diff[AccAxes+g] * GyroMul;
    end

    always_comb begin
        n_data = '0;
        for (int a = 0; a < AccAxes; a++) begin
            n_data[a*AccW +: AccW] = i_diff[a];
        end
        for (int k = 0; k < Axes - AccAxes; k++) begin
            n_data[AccAxes*AccW + k*GyroW +: GyroW] = w_prod[k][GyroShift +: GyroW];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_take) begin
            r_valid <= 1'b1;
        end else if (i_tready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take) begin
            r_data  <= n_data;
            r_flags <= i_flags;
        end
    end

    assign o_tvalid = r_valid;
    assign o_tdata  = r_data;
    assign o_tuser  = r_flags;

endmodule
